/* rtl/erm_pkg.sv */
// Shared types and constants for the exit record match table.
// Used by erm_table and exit_record_match_table_unit; depends on nothing else.

package erm_pkg;

   localparam int TABLE_ENTRIES = 16;

   localparam logic KIND_RECORD  = 1'b0;
   localparam logic KIND_COLLECT = 1'b1;

   typedef enum logic [1:0] {
      STATUS_STORED    = 2'd0,
      STATUS_OVERWROTE = 2'd1,
      STATUS_COLLECTED = 2'd2,
      STATUS_NOMATCH   = 2'd3
   } status_type;

   typedef struct packed {
      logic               kind;
      logic [31:0]        exited_pid;
      logic [31:0]        parent_id;
      logic signed [31:0] exit_value;
      logic [31:0]        wanted_pid;
   } op_type;

   typedef struct packed {
      status_type         status;
      logic [31:0]        collected_pid;
      logic signed [31:0] collected_code;
   } result_type;

endpackage

/* rtl/exit_record_match_table_unit.sv */
// Top level of the exit record match table: handshake stages around erm_table.
// Depends on erm_pkg and erm_table.

// The block keeps up to 16 completion records and takes one operation per
// cycle while results are not held back. A request is captured in an input
// register; when it advances, the whole table is searched and updated in one
// pass and the result goes to an output register, and a new request can enter
// the input register in the same cycle as its predecessor advances.
// While a result waits, one more request can still enter the input register;
// after that the input stalls until the waiting result transfers.

module exit_record_match_table_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic [31:0]        req_exited_pid,
   input  logic [31:0]        req_parent_id,
   input  logic signed [31:0] req_exit_value,
   input  logic [31:0]        req_wanted_pid,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [31:0]        rsp_collected_pid,
   output logic signed [31:0] rsp_collected_code
);

   logic                in_valid_ff;
   logic                in_valid_in;
   erm_pkg::op_type     op_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   erm_pkg::result_type rsp_ff;
   erm_pkg::result_type table_result;
   logic                advance;
   logic                accept;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff.kind       <= req_kind;
         op_ff.exited_pid <= req_exited_pid;
         op_ff.parent_id  <= req_parent_id;
         op_ff.exit_value <= req_exit_value;
         op_ff.wanted_pid <= req_wanted_pid;
      end
   end

   erm_table u_table (
      .clock  (clock),
      .reset  (reset),
      .op_en  (advance),
      .op     (op_ff),
      .result (table_result)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= table_result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_collected_pid  = rsp_ff.collected_pid;
   assign rsp_collected_code = rsp_ff.collected_code;

`ifndef SYNTHESIS
   a_zero_unless_collected: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != erm_pkg::STATUS_COLLECTED) |->
         (rsp_collected_pid == 32'd0) && (rsp_collected_code == 32'sd0))
      else $error("nonzero result fields without a collect");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request taken while both stages are full and stalled");

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff))
      else $error("result appeared without a request in the input stage");
`endif

endmodule

/* rtl/erm_table.sv */
// Record table storage with a parallel search over all entries.
// Depends on erm_pkg for the table size, operation and result types.

module erm_table (
   input  logic                clock,
   input  logic                reset,
   input  logic                op_en,
   input  erm_pkg::op_type     op,
   output erm_pkg::result_type result
);

   localparam int N = erm_pkg::TABLE_ENTRIES;

   logic [N-1:0]        valid_ff;
   logic [N-1:0]        valid_in;
   logic [31:0]         pid_ff    [N];
   logic [31:0]         parent_ff [N];
   logic signed [31:0]  code_ff   [N];

   logic [N-1:0]        free_vec;
   logic [N-1:0]        free_sel;
   logic [N-1:0]        wr_sel;
   logic                full;
   logic [N-1:0]        match_vec;
   logic [N-1:0]        hit_sel;
   logic                any_wanted;
   logic [31:0]         hit_pid;
   logic signed [31:0]  hit_code;

   // Lowest free entry, isolated as a one-hot vector; entry 0 when full.
   assign free_vec   = ~valid_ff;
   assign free_sel   = free_vec & (~free_vec + N'(1));
   assign full       = &valid_ff;
   assign wr_sel     = full ? N'(1) : free_sel;
   assign any_wanted = (op.wanted_pid == 32'd0);

   always_comb begin
      for (int i = 0; i < N; i++) begin
         match_vec[i] = valid_ff[i] && (parent_ff[i] == op.parent_id) &&
                        (any_wanted || (pid_ff[i] == op.wanted_pid));
      end
   end

   assign hit_sel = match_vec & (~match_vec + N'(1));

   // The hit vector is one-hot or empty, so an AND-OR gathers the entry.
   always_comb begin
      hit_pid  = '0;
      hit_code = '0;
      for (int i = 0; i < N; i++) begin
         if (hit_sel[i]) begin
            hit_pid  = hit_pid | pid_ff[i];
            hit_code = hit_code | code_ff[i];
         end
      end
   end

   always_comb begin
      if (op.kind == erm_pkg::KIND_RECORD) begin
         valid_in              = valid_ff | wr_sel;
         result.status         = full ? erm_pkg::STATUS_OVERWROTE
                                      : erm_pkg::STATUS_STORED;
         result.collected_pid  = '0;
         result.collected_code = '0;
      end else begin
         valid_in              = valid_ff & ~hit_sel;
         result.status         = (|match_vec) ? erm_pkg::STATUS_COLLECTED
                                              : erm_pkg::STATUS_NOMATCH;
         result.collected_pid  = hit_pid;
         result.collected_code = hit_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (op_en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         if (op_en && (op.kind == erm_pkg::KIND_RECORD) && wr_sel[i]) begin
            pid_ff[i]    <= op.exited_pid;
            parent_ff[i] <= op.parent_id;
            code_ff[i]   <= op.exit_value;
         end
      end
   end

`ifndef SYNTHESIS
   a_hit_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_sel))
      else $error("more than one entry selected by a collect");

   a_overwrite_only_full: assert property (@(posedge clock) disable iff (reset)
      op_en && (result.status == erm_pkg::STATUS_OVERWROTE) |-> (&valid_ff))
      else $error("entry zero overwritten while a free entry existed");

   a_collect_frees_one: assert property (@(posedge clock) disable iff (reset)
      op_en && (result.status == erm_pkg::STATUS_COLLECTED) |=>
         ($countones(valid_ff) == $countones($past(valid_ff)) - 1))
      else $error("collect did not free exactly one entry");

   a_record_fills: assert property (@(posedge clock) disable iff (reset)
      op_en && (op.kind == erm_pkg::KIND_RECORD) |=> (valid_ff != '0))
      else $error("table empty after a record");
`endif

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Testbench for exit_record_match_table_unit: directed and random record and collect
// operations checked against a cycle-free table predictor. Depends on erm_pkg and the RTL.

module testbench;
   import erm_pkg::*;

   class exit_table_scoreboard;
      bit                 live      [TABLE_ENTRIES];
      logic [31:0]        pid_of    [TABLE_ENTRIES];
      logic [31:0]        parent_of [TABLE_ENTRIES];
      logic signed [31:0] code_of   [TABLE_ENTRIES];
      result_type         awaited_results [$];
      int                 errors;

      function new();
         foreach (live[i]) live[i] = 1'b0;
         errors = 0;
      endfunction

      // Applies one operation to the table copy and returns the result it yields.
      function result_type apply_operation(op_type op);
         result_type r;
         int         slot;
         r.status         = STATUS_NOMATCH;
         r.collected_pid  = '0;
         r.collected_code = '0;
         slot = -1;
         if (op.kind == KIND_RECORD) begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
               if (slot < 0 && !live[i]) slot = i;
            r.status = (slot < 0) ? STATUS_OVERWROTE : STATUS_STORED;
            if (slot < 0) slot = 0;
            pid_of[slot]    = op.exited_pid;
            parent_of[slot] = op.parent_id;
            code_of[slot]   = op.exit_value;
            live[slot]      = 1'b1;
         end else begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
               if (slot < 0 && live[i] && parent_of[i] == op.parent_id &&
                   (op.wanted_pid == 32'd0 || pid_of[i] == op.wanted_pid))
                  slot = i;
            if (slot >= 0) begin
               r.status         = STATUS_COLLECTED;
               r.collected_pid  = pid_of[slot];
               r.collected_code = code_of[slot];
               live[slot]       = 1'b0;
            end
         end
         return r;
      endfunction

      function void note_request(op_type op);
         awaited_results.push_back(apply_operation(op));
      endfunction

      function void check_result(logic [1:0] status, logic [31:0] pid,
                                 logic signed [31:0] code);
         result_type want;
         if (awaited_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: status %0d pid %h code %0d", status, pid, code);
            return;
         end
         want = awaited_results.pop_front();
         if (status !== want.status || pid !== want.collected_pid ||
             code !== want.collected_code) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: status exp %0d got %0d, pid exp %h got %h, code exp %0d got %0d",
                        want.status, status, want.collected_pid, pid,
                        want.collected_code, code);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_kind;
   logic [31:0]        req_exited_pid;
   logic [31:0]        req_parent_id;
   logic signed [31:0] req_exit_value;
   logic [31:0]        req_wanted_pid;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [1:0]         rsp_status;
   logic [31:0]        rsp_collected_pid;
   logic signed [31:0] rsp_collected_code;

   exit_table_scoreboard sb;
   op_type               accepted_op;
   bit                   quiet;
   bit                   hold_wanted;
   logic [31:0]          parent_pool [8];
   logic [31:0]          recent_pid [$];
   logic [31:0]          recent_parent [$];

   exit_record_match_table_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_exited_pid     (req_exited_pid),
      .req_parent_id      (req_parent_id),
      .req_exit_value     (req_exit_value),
      .req_wanted_pid     (req_wanted_pid),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_collected_pid  (rsp_collected_pid),
      .rsp_collected_code (rsp_collected_code)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         accepted_op.kind       = req_kind;
         accepted_op.exited_pid = req_exited_pid;
         accepted_op.parent_id  = req_parent_id;
         accepted_op.exit_value = req_exit_value;
         accepted_op.wanted_pid = req_wanted_pid;
         sb.note_request(accepted_op);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_status, rsp_collected_pid, rsp_collected_code);
   end

   // Result side: ready stretches, short and occasional long stalls, and one
   // long hold-off on request from the sender so that the block backs up.
   initial begin
      int stall_left;
      int run_left;
      int pick;
      stall_left = 0;
      run_left = 0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            stall_left = 300;
            run_left = 0;
         end
         if (stall_left == 0 && run_left == 0) begin
            pick = $urandom_range(99);
            if (pick < 55)      run_left = $urandom_range(40, 1);
            else if (pick < 95) stall_left = $urandom_range(3, 1);
            else                stall_left = $urandom_range(40, 10);
         end
         rsp_ready <= (stall_left == 0);
         if (stall_left > 0) stall_left--;
         else if (run_left > 0) run_left--;
      end
   end

   function automatic int pick_gap();
      int pick;
      if (quiet) return 0;
      pick = $urandom_range(99);
      if (pick < 60) return 0;
      if (pick < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_op(input logic kind, input logic [31:0] pid, input logic [31:0] parent,
                          input logic signed [31:0] value, input logic [31:0] wanted);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_kind       <= kind;
      req_exited_pid <= pid;
      req_parent_id  <= parent;
      req_exit_value <= value;
      req_wanted_pid <= wanted;
      req_valid      <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic send_random_op();
      logic [31:0] pid;
      logic [31:0] parent;
      logic [31:0] wanted;
      int          pick;
      int          idx;
      pick = $urandom_range(99);
      if (pick < 50 || recent_pid.size() == 0) begin
         parent = ($urandom_range(9) == 0) ? $urandom() : parent_pool[$urandom_range(7)];
         case ($urandom_range(9))
            0:       pid = 32'd0;
            1, 2, 3: pid = $urandom_range(20, 1);
            default: pid = $urandom();
         endcase
         send_op(KIND_RECORD, pid, parent, $urandom(), $urandom());
         recent_pid.push_back(pid);
         recent_parent.push_back(parent);
         if (recent_pid.size() > 32) begin
            void'(recent_pid.pop_front());
            void'(recent_parent.pop_front());
         end
      end else begin
         if (pick < 85) begin
            // Aim at a record made recently, by id or as any child of its parent.
            idx = $urandom_range(recent_pid.size() - 1);
            parent = recent_parent[idx];
            wanted = ($urandom_range(2) == 0) ? 32'd0 : recent_pid[idx];
         end else if (pick < 93) begin
            parent = parent_pool[$urandom_range(7)];
            wanted = 32'd0;
         end else begin
            parent = ($urandom_range(1) == 0) ? $urandom() : parent_pool[$urandom_range(7)];
            wanted = $urandom();
         end
         send_op(KIND_COLLECT, $urandom(), parent, $urandom(), wanted);
      end
   endtask

   initial begin
      int waited;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_RECORD;
      req_exited_pid = '0;
      req_parent_id = '0;
      req_exit_value = '0;
      req_wanted_pid = '0;
      rsp_ready = 1'b0;
      quiet = 1'b0;
      hold_wanted = 1'b0;
      parent_pool[0] = 32'd0;
      parent_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 8; i++) parent_pool[i] = $urandom();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, filling the table, overwrite of entry zero when full,
      // any-child and by-id collects, and misses on id and on parent.
      send_op(KIND_RECORD, 32'hFFFF_FFFF, 32'd0, 32'sh8000_0000, 32'hFFFF_FFFF);
      send_op(KIND_RECORD, 32'd0, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'd0);
      for (int i = 0; i < TABLE_ENTRIES - 2; i++)
         send_op(KIND_RECORD, 32'd100 + i, 32'd5, -i, 32'd0);
      send_op(KIND_RECORD, 32'h0000_ABCD, 32'd7, -1, 32'd0);
      send_op(KIND_COLLECT, 32'd0, 32'd7, 32'sd0, 32'd0);
      send_op(KIND_COLLECT, 32'd0, 32'hFFFF_FFFF, 32'sd0, 32'd0);
      send_op(KIND_COLLECT, 32'd0, 32'd5, 32'sd0, 32'd107);
      send_op(KIND_COLLECT, 32'd0, 32'd5, 32'sd0, 32'd0);
      send_op(KIND_COLLECT, 32'd0, 32'd5, 32'sd0, 32'd107);
      send_op(KIND_COLLECT, 32'd0, 32'd9, 32'sd0, 32'd0);
      send_op(KIND_RECORD, 32'd55, 32'd5, 32'sd3, 32'd0);
      send_op(KIND_COLLECT, 32'hFFFF_FFFF, 32'd5, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);

      for (int n = 0; n < 1325; n++) begin
         if (n % 100 == 0) quiet = ($urandom_range(9) < 3);
         if (n == 500) hold_wanted = 1'b1;
         send_random_op();
      end
      req_valid <= 1'b0;

      waited = 0;
      while (sb.awaited_results.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      sb.errors += sb.awaited_results.size();
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
